FILE: sv/tvru_pkg.sv
package tvru_pkg;

   localparam int PatternBytes   = 8192;
   localparam int NameBytes      = 4096;
   localparam int DotsPerLine    = 341;
   localparam int LinesPerFrame  = 262;
   localparam int VblankLine     = 241;

   localparam int PatAw  = $clog2(PatternBytes);
   localparam int NameAw = $clog2(NameBytes);

   localparam logic [2:0] FUNC_READ  = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_TICK  = 3'd2;
   localparam logic [2:0] FUNC_LOAD  = 3'd3;
   localparam logic [2:0] FUNC_POLL  = 3'd4;
   localparam logic [2:0] FUNC_PIXEL = 3'd5;

   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   typedef struct packed {
      logic [2:0]  func;
      logic [2:0]  reg_index;
      logic [7:0]  data;
      logic [7:0]  cpu_cycles;
      logic [12:0] pattern_addr;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        nmi_taken;
      logic [23:0] pixel_color;
   } rsp_type;

   function automatic logic [23:0] rgb_lookup(input logic [5:0] c);
      logic [23:0] r;
      unique case (c)
         6'h00: r = 24'h545454; 6'h01: r = 24'h001E74; 6'h02: r = 24'h081090;
         6'h03: r = 24'h300088; 6'h04: r = 24'h440064; 6'h05: r = 24'h5C0030;
         6'h06: r = 24'h540400; 6'h07: r = 24'h3C1800; 6'h08: r = 24'h202A00;
         6'h09: r = 24'h083A00; 6'h0A: r = 24'h004200; 6'h0B: r = 24'h004038;
         6'h0C: r = 24'h00323C;
         6'h10: r = 24'h989698; 6'h11: r = 24'h084CC4; 6'h12: r = 24'h3032EC;
         6'h13: r = 24'h5C1EE4; 6'h14: r = 24'h8814B0; 6'h15: r = 24'hA01464;
         6'h16: r = 24'hA02A20; 6'h17: r = 24'h884600; 6'h18: r = 24'h606A00;
         6'h19: r = 24'h288000; 6'h1A: r = 24'h008A00; 6'h1B: r = 24'h00886C;
         6'h1C: r = 24'h0078A0;
         6'h20: r = 24'hECEEE4; 6'h21: r = 24'h4C9AEC; 6'h22: r = 24'h787CF4;
         6'h23: r = 24'hB062EC; 6'h24: r = 24'hD45ED4; 6'h25: r = 24'hE05C8C;
         6'h26: r = 24'hF07858; 6'h27: r = 24'hECA044; 6'h28: r = 24'hB8C43C;
         6'h29: r = 24'h70D02C; 6'h2A: r = 24'h4CD05C; 6'h2B: r = 24'h4CC4A0;
         6'h2C: r = 24'h58B0D8; 6'h2D: r = 24'h3C3C3C;
         6'h30: r = 24'hECEEE4; 6'h31: r = 24'hA8CCEC; 6'h32: r = 24'hBCBCEC;
         6'h33: r = 24'hD4B2EC; 6'h34: r = 24'hECAEE4; 6'h35: r = 24'hECAECC;
         6'h36: r = 24'hF0B4A8; 6'h37: r = 24'hECC4A0; 6'h38: r = 24'hD8D898;
         6'h39: r = 24'hB8E08C; 6'h3A: r = 24'hA8E0A8; 6'h3B: r = 24'hA8D8C8;
         6'h3C: r = 24'hA8CCEC; 6'h3D: r = 24'hA8A8A8;
         default: r = 24'h000000;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] pal_slot(input logic [4:0] p);
      return ((p & 5'h13) == 5'h10) ? (p & 5'h0F) : p;
   endfunction

endpackage

FILE: sv/tvru_timer.sv
module tvru_timer (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] cpu_cycles,
   input  logic       nmi_enable,
   output logic       busy,
   output logic       vbl_set,
   output logic       vbl_clr,
   output logic       nmi_set
);
   logic [9:0] left_ff, left_in;
   logic [8:0] dot_ff, dot_in, line_ff, line_in, line_nx;
   logic [8:0] dot_nx;

   always_comb begin
      left_in = left_ff;
      dot_in  = dot_ff;
      line_in = line_ff;
      vbl_set = 1'b0;
      vbl_clr = 1'b0;
      nmi_set = 1'b0;
      dot_nx  = dot_ff + 9'd1;
      line_nx = line_ff + 9'd1;
      if (start) begin
         left_in = {2'b0, cpu_cycles} + {1'b0, cpu_cycles, 1'b0};
      end else if (left_ff != '0) begin
         left_in = left_ff - 10'd1;
         dot_in  = dot_nx;
         if (dot_nx >= 9'(tvru_pkg::DotsPerLine)) begin
            dot_in  = '0;
            line_in = line_nx;
            if (line_nx == 9'(tvru_pkg::VblankLine)) begin
               vbl_set = 1'b1;
               nmi_set = nmi_enable;
            end
            if (line_nx >= 9'(tvru_pkg::LinesPerFrame)) begin
               line_in = '0;
               vbl_clr = 1'b1;
            end
         end
      end
   end

   assign busy = (left_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         dot_ff  <= '0;
         line_ff <= '0;
      end else begin
         left_ff <= left_in;
         dot_ff  <= dot_in;
         line_ff <= line_in;
      end
   end
endmodule

FILE: sv/tile_video_register_unit_core.sv
// Tile picture unit with a CPU-style register port and background pixel query.
// req_ carries one operation per transfer (bus read/write, tick, pattern load,
// NMI poll, pixel query); rsp_ returns exactly one result per operation, in
// order. One item is in work at a time. Register and poll operations, data-port
// writes and pattern loads pass through the execute and done states; data-port
// reads add the memory read state; a pixel query walks name,
// two pattern, attribute and one palette read; a tick runs one dot
// per cycle, 3*cpu_cycles dots in all.
// After reset a clearing pass writes zero to every name and palette entry,
// one per cycle; req_ready stays low during it.
// The result sits in an output register; while the receiver stalls it is
// held and no new item is taken until it is transferred.
module tile_video_register_unit_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tvru_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tvru_pkg::rsp_type    rsp_data
);
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_EXEC  = 4'd2;
   localparam logic [3:0] ST_MEMRD = 4'd3;
   localparam logic [3:0] ST_TICK  = 4'd4;
   localparam logic [3:0] ST_PNAME = 4'd5;
   localparam logic [3:0] ST_PLO   = 4'd6;
   localparam logic [3:0] ST_PHI   = 4'd7;
   localparam logic [3:0] ST_PATR  = 4'd8;
   localparam logic [3:0] ST_PPAL  = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   localparam int Aw = tvru_pkg::NameAw;

   logic [3:0]  state_ff, state_in;
   tvru_pkg::req_type req_ff;
   logic [Aw:0] clr_ff;
   logic [7:0]  ctrl_ff, mask_ff, status_ff, scrh_ff, scrv_ff;
   logic        toggle_ff, nmi_ff;
   logic [13:0] vaddr_ff;
   logic        rsp_valid_ff;
   tvru_pkg::rsp_type rsp_ff, rsp_in;
   logic [13:0] rd_va_ff;

   logic [7:0] pat_mem [tvru_pkg::PatternBytes];
   logic [7:0] name_mem [tvru_pkg::NameBytes];
   logic [5:0] pal_mem [32];
   logic [7:0] pat_q, name_q;
   logic [5:0] pal_q;
   logic [tvru_pkg::PatAw-1:0] pat_ra;
   logic [Aw-1:0] name_ra;
   logic [4:0] pal_ra;
   logic        pat_we, name_we, pal_we;
   logic [tvru_pkg::PatAw-1:0] pat_wa;
   logic [Aw-1:0] name_wa;
   logic [4:0] pal_wa;
   logic [7:0] name_wd;
   logic [5:0] pal_wd;

   logic [7:0] tile_ff, lo_ff, hi_ff;
   logic [1:0] pix_ff;

   logic t_busy, t_vset, t_vclr, t_nmi, t_start;

   tvru_timer u_timer (
      .clock      (clock),
      .reset      (reset),
      .start      (t_start),
      .cpu_cycles (req_ff.cpu_cycles),
      .nmi_enable (ctrl_ff[7]),
      .busy       (t_busy),
      .vbl_set    (t_vset),
      .vbl_clr    (t_vclr),
      .nmi_set    (t_nmi)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [4:0] tx, ty;
   logic [2:0] px, py;
   logic [13:0] va;
   logic [13:0] va_step;
   logic [2:0]  sh;
   logic [1:0]  attr_bits;
   logic [4:0]  pidx;
   logic        is_pal, is_name;

   always_comb begin
      tx = req_ff.pixel_x[7:3];
      ty = req_ff.pixel_y[7:3];
      px = req_ff.pixel_x[2:0];
      py = req_ff.pixel_y[2:0];
      va = vaddr_ff;
      is_pal  = (va >= 14'h3F00);
      is_name = (va >= 14'h2000) && !is_pal;
      va_step = ctrl_ff[2] ? (va + 14'd32) : (va + 14'd1);
      sh = {ty[1], tx[1], 1'b0};
      attr_bits = 2'(name_q >> sh);
      pidx = {1'b0, attr_bits, pix_ff};
      if (pix_ff == 2'd0) pidx = '0;
   end

   // read address mux
   always_comb begin
      pat_ra  = va[tvru_pkg::PatAw-1:0];
      name_ra = Aw'(va[11:0]);
      pal_ra  = tvru_pkg::pal_slot(va[4:0]);
      unique case (state_ff)
         ST_PNAME: name_ra = Aw'({ty, tx});
         ST_PLO:   pat_ra = tvru_pkg::PatAw'({name_q, 1'b0, py});
         ST_PHI:   pat_ra = tvru_pkg::PatAw'({tile_ff, 1'b1, py});
         ST_PATR:  name_ra = Aw'({10'h3C0 | {4'd0, ty[4:2], tx[4:2]}});
         ST_PPAL:  pal_ra = tvru_pkg::pal_slot(pidx);
         default: ;
      endcase
   end

   always_comb begin
      pat_we  = 1'b0;
      name_we = 1'b0;
      pal_we  = 1'b0;
      pat_wa  = req_ff.pattern_addr[tvru_pkg::PatAw-1:0];
      name_wa = Aw'(va[11:0]);
      pal_wa  = tvru_pkg::pal_slot(va[4:0]);
      name_wd = req_ff.data;
      pal_wd  = req_ff.data[5:0];
      if (state_ff == ST_CLEAR) begin
         name_we = 1'b1;
         pal_we  = 1'b1;
         name_wa = clr_ff[Aw-1:0];
         pal_wa  = clr_ff[4:0];
         name_wd = '0;
         pal_wd  = '0;
      end else if (state_ff == ST_EXEC) begin
         pat_we  = (req_ff.func == tvru_pkg::FUNC_LOAD);
         if (req_ff.func == tvru_pkg::FUNC_WRITE && req_ff.reg_index == tvru_pkg::REG_DATA) begin
            name_we = is_name;
            pal_we  = is_pal;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[pat_wa] <= req_ff.data;
      if (name_we) name_mem[name_wa] <= name_wd;
      if (pal_we) pal_mem[pal_wa] <= pal_wd;
      pat_q  <= pat_mem[pat_ra];
      name_q <= name_mem[name_ra];
      pal_q  <= pal_mem[pal_ra];
   end

   assign t_start = (state_ff == ST_EXEC) && (req_ff.func == tvru_pkg::FUNC_TICK);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == (Aw+1)'(tvru_pkg::NameBytes - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && req_ready) state_in = ST_EXEC;
         ST_EXEC: begin
            priority case (req_ff.func)
               tvru_pkg::FUNC_TICK:  state_in = ST_TICK;
               tvru_pkg::FUNC_PIXEL: state_in = ST_PNAME;
               tvru_pkg::FUNC_READ:
                  state_in = (req_ff.reg_index == tvru_pkg::REG_DATA) ? ST_MEMRD : ST_DONE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MEMRD: state_in = ST_DONE;
         ST_TICK:  if (!t_busy) state_in = ST_DONE;
         ST_PNAME: state_in = ST_PLO;
         ST_PLO:   state_in = ST_PHI;
         ST_PHI:   state_in = ST_PATR;
         ST_PATR:  state_in = ST_PPAL;
         ST_PPAL:  state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // build the result across the states of one item
   always_comb begin
      rsp_in = rsp_ff;
      if (state_ff == ST_EXEC) begin
         rsp_in = '0;
         if (req_ff.func == tvru_pkg::FUNC_READ && req_ff.reg_index == tvru_pkg::REG_STATUS)
            rsp_in.read_data = status_ff;
         if (req_ff.func == tvru_pkg::FUNC_POLL) rsp_in.nmi_taken = nmi_ff;
      end
      // unbuffered data-port read: select memory by the pre-step address
      if (state_ff == ST_MEMRD) begin
         if (rd_va_ff >= 14'h3F00) rsp_in.read_data = {2'b00, pal_q};
         else if (rd_va_ff >= 14'h2000) rsp_in.read_data = name_q;
         else rsp_in.read_data = pat_q;
      end
      if (state_ff == ST_DONE && req_ff.func == tvru_pkg::FUNC_PIXEL)
         rsp_in.pixel_color = tvru_pkg::rgb_lookup(pal_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ctrl_ff      <= '0;
         mask_ff      <= '0;
         status_ff    <= '0;
         scrh_ff      <= '0;
         scrv_ff      <= '0;
         toggle_ff    <= 1'b0;
         nmi_ff       <= 1'b0;
         vaddr_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (t_vset) status_ff[7] <= 1'b1;
         if (t_vclr) status_ff[7] <= 1'b0;
         if (t_nmi) nmi_ff <= 1'b1;
         if (state_ff == ST_EXEC) begin
            unique case (req_ff.func)
               tvru_pkg::FUNC_READ: begin
                  if (req_ff.reg_index == tvru_pkg::REG_STATUS) begin
                     status_ff[7] <= 1'b0;
                     toggle_ff <= 1'b0;
                  end else if (req_ff.reg_index == tvru_pkg::REG_DATA) begin
                     vaddr_ff <= va_step;
                  end
               end
               tvru_pkg::FUNC_WRITE: begin
                  unique case (req_ff.reg_index)
                     tvru_pkg::REG_CTRL: ctrl_ff <= req_ff.data;
                     tvru_pkg::REG_MASK: mask_ff <= req_ff.data;
                     tvru_pkg::REG_SCROLL: begin
                        if (!toggle_ff) scrh_ff <= req_ff.data;
                        else scrv_ff <= req_ff.data;
                        toggle_ff <= !toggle_ff;
                     end
                     tvru_pkg::REG_ADDR: begin
                        if (!toggle_ff) vaddr_ff <= {req_ff.data[5:0], 8'h00};
                        else vaddr_ff <= {vaddr_ff[13:8], req_ff.data};
                        toggle_ff <= !toggle_ff;
                     end
                     tvru_pkg::REG_DATA: vaddr_ff <= va_step;
                     default: ;
                  endcase
               end
               tvru_pkg::FUNC_POLL: begin
                  nmi_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      if (state_ff == ST_EXEC) rd_va_ff <= va;
      rsp_ff <= rsp_in;
      if (state_ff == ST_PLO) tile_ff <= name_q;
      if (state_ff == ST_PHI) lo_ff <= pat_q;
      if (state_ff == ST_PATR) begin
         hi_ff  <= pat_q;
         pix_ff <= {pat_q[3'd7 - px], lo_ff[3'd7 - px]};
      end
   end

   logic unused_ok;
   assign unused_ok = ^{mask_ff, scrh_ff, scrv_ff, hi_ff};
endmodule

FILE: verif/tile_video_register_unit_core_test.sv
`timescale 1ns / 100ps

module tile_video_register_unit_core_test;

   localparam logic [2:0] REG_SPARE3  = 3'd3;
   localparam logic [2:0] REG_SPARE4  = 3'd4;
   localparam logic [2:0] FUNC_SPARE6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tvru_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tvru_pkg::rsp_type rsp_data;

   tile_video_register_unit_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // predicted block state
   logic [7:0]  m_ctrl, m_mask, m_status, m_scroll_h, m_scroll_v;
   logic        m_toggle, m_nmi;
   logic [13:0] m_vaddr;
   int unsigned m_dot, m_line;
   logic [7:0]  m_pattern [tvru_pkg::PatternBytes];
   bit          m_loaded [tvru_pkg::PatternBytes];
   logic [7:0]  m_name [tvru_pkg::NameBytes];
   logic [5:0]  m_palette [32];

   tvru_pkg::rsp_type pending_rsp [$];
   int unsigned mismatch_count = 0;
   int unsigned rsp_count = 0;
   int unsigned sent_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_cycles = 0;
   int unsigned hold_req = 0;
   int unsigned hold_done = 0;
   int unsigned nmi_seen = 0;
   int unsigned vblank_seen = 0;

   function automatic logic [23:0] color_of(input logic [5:0] c);
      logic [23:0] r;
      case (c)
         6'h00: r = 24'h545454; 6'h01: r = 24'h001E74; 6'h02: r = 24'h081090;
         6'h03: r = 24'h300088; 6'h04: r = 24'h440064; 6'h05: r = 24'h5C0030;
         6'h06: r = 24'h540400; 6'h07: r = 24'h3C1800; 6'h08: r = 24'h202A00;
         6'h09: r = 24'h083A00; 6'h0A: r = 24'h004200; 6'h0B: r = 24'h004038;
         6'h0C: r = 24'h00323C;
         6'h10: r = 24'h989698; 6'h11: r = 24'h084CC4; 6'h12: r = 24'h3032EC;
         6'h13: r = 24'h5C1EE4; 6'h14: r = 24'h8814B0; 6'h15: r = 24'hA01464;
         6'h16: r = 24'hA02A20; 6'h17: r = 24'h884600; 6'h18: r = 24'h606A00;
         6'h19: r = 24'h288000; 6'h1A: r = 24'h008A00; 6'h1B: r = 24'h00886C;
         6'h1C: r = 24'h0078A0;
         6'h20: r = 24'hECEEE4; 6'h21: r = 24'h4C9AEC; 6'h22: r = 24'h787CF4;
         6'h23: r = 24'hB062EC; 6'h24: r = 24'hD45ED4; 6'h25: r = 24'hE05C8C;
         6'h26: r = 24'hF07858; 6'h27: r = 24'hECA044; 6'h28: r = 24'hB8C43C;
         6'h29: r = 24'h70D02C; 6'h2A: r = 24'h4CD05C; 6'h2B: r = 24'h4CC4A0;
         6'h2C: r = 24'h58B0D8; 6'h2D: r = 24'h3C3C3C;
         6'h30: r = 24'hECEEE4; 6'h31: r = 24'hA8CCEC; 6'h32: r = 24'hBCBCEC;
         6'h33: r = 24'hD4B2EC; 6'h34: r = 24'hECAEE4; 6'h35: r = 24'hECAECC;
         6'h36: r = 24'hF0B4A8; 6'h37: r = 24'hECC4A0; 6'h38: r = 24'hD8D898;
         6'h39: r = 24'hB8E08C; 6'h3A: r = 24'hA8E0A8; 6'h3B: r = 24'hA8D8C8;
         6'h3C: r = 24'hA8CCEC; 6'h3D: r = 24'hA8A8A8;
         default: r = 24'h000000;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] mirror_slot(input logic [13:0] a);
      logic [4:0] p;
      p = a[4:0];
      if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
      return p;
   endfunction

   function automatic void advance_vaddr();
      m_vaddr = m_vaddr + (m_ctrl[2] ? 14'd32 : 14'd1);
   endfunction

   function automatic logic [7:0] video_read(input logic [13:0] a);
      if (a < 14'h2000) return m_pattern[a[12:0]];
      if (a < 14'h3F00) return m_name[a[11:0]];
      return {2'b00, m_palette[mirror_slot(a)]};
   endfunction

   // true when a data-port read or pixel query would touch an unloaded pattern byte
   function automatic bit touches_unloaded(input tvru_pkg::req_type r);
      logic [7:0] tile;
      logic [12:0] base;
      if (r.func == tvru_pkg::FUNC_READ && r.reg_index == tvru_pkg::REG_DATA
          && m_vaddr < 14'h2000)
         return !m_loaded[m_vaddr[12:0]];
      if (r.func == tvru_pkg::FUNC_PIXEL) begin
         tile = m_name[((r.pixel_y >> 3) * 32 + (r.pixel_x >> 3)) % tvru_pkg::NameBytes];
         base = {1'b0, tile, 4'h0};
         return !m_loaded[base + r.pixel_y[2:0]] || !m_loaded[base + 8 + r.pixel_y[2:0]];
      end
      return 1'b0;
   endfunction

   function automatic tvru_pkg::rsp_type predict_result(input tvru_pkg::req_type r);
      tvru_pkg::rsp_type o;
      int unsigned n, tx, ty, sh;
      logic [7:0] tile, attr;
      logic [12:0] base;
      logic [1:0] pix;
      logic [4:0] idx;
      o = '0;
      case (r.func)
         tvru_pkg::FUNC_READ: begin
            if (r.reg_index == tvru_pkg::REG_STATUS) begin
               o.read_data = m_status;
               if (m_status[7]) vblank_seen++;
               m_status[7] = 1'b0;
               m_toggle = 1'b0;
            end else if (r.reg_index == tvru_pkg::REG_DATA) begin
               o.read_data = video_read(m_vaddr);
               advance_vaddr();
            end
         end
         tvru_pkg::FUNC_WRITE: begin
            case (r.reg_index)
               tvru_pkg::REG_CTRL: m_ctrl = r.data;
               tvru_pkg::REG_MASK: m_mask = r.data;
               tvru_pkg::REG_SCROLL: begin
                  if (!m_toggle) m_scroll_h = r.data; else m_scroll_v = r.data;
                  m_toggle = !m_toggle;
               end
               tvru_pkg::REG_ADDR: begin
                  if (!m_toggle) m_vaddr = {r.data[5:0], 8'h00};
                  else m_vaddr = {m_vaddr[13:8], r.data};
                  m_toggle = !m_toggle;
               end
               tvru_pkg::REG_DATA: begin
                  if (m_vaddr >= 14'h3F00) m_palette[mirror_slot(m_vaddr)] = r.data[5:0];
                  else if (m_vaddr >= 14'h2000) m_name[m_vaddr[11:0]] = r.data;
                  advance_vaddr();
               end
               default: ;
            endcase
         end
         tvru_pkg::FUNC_TICK: begin
            n = r.cpu_cycles * 3;
            repeat (n) begin
               m_dot++;
               if (m_dot >= tvru_pkg::DotsPerLine) begin
                  m_dot = 0;
                  m_line++;
                  if (m_line == tvru_pkg::VblankLine) begin
                     m_status[7] = 1'b1;
                     if (m_ctrl[7]) m_nmi = 1'b1;
                  end
                  if (m_line >= tvru_pkg::LinesPerFrame) begin
                     m_line = 0;
                     m_status[7] = 1'b0;
                  end
               end
            end
         end
         tvru_pkg::FUNC_LOAD: begin
            m_pattern[r.pattern_addr] = r.data;
            m_loaded[r.pattern_addr] = 1'b1;
         end
         tvru_pkg::FUNC_POLL: begin
            if (m_nmi) begin
               m_nmi = 1'b0;
               o.nmi_taken = 1'b1;
               nmi_seen++;
            end
         end
         tvru_pkg::FUNC_PIXEL: begin
            tx = r.pixel_x >> 3;
            ty = r.pixel_y >> 3;
            tile = m_name[(ty * 32 + tx) % tvru_pkg::NameBytes];
            base = {1'b0, tile, 4'h0};
            pix[0] = m_pattern[base + r.pixel_y[2:0]][7 - r.pixel_x[2:0]];
            pix[1] = m_pattern[base + 8 + r.pixel_y[2:0]][7 - r.pixel_x[2:0]];
            idx = '0;
            if (pix != 2'b00) begin
               attr = m_name[(12'h3C0 + (ty >> 2) * 8 + (tx >> 2)) % tvru_pkg::NameBytes];
               sh = ((((ty & 3) >> 1) * 2) + ((tx & 3) >> 1)) * 2;
               idx = {1'b0, 2'((attr >> sh) & 8'd3), pix};
            end
            if (idx[1:0] == 2'b00) idx = '0;
            o.pixel_color = color_of(m_palette[idx]);
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_item(input tvru_pkg::req_type r);
      if (touches_unloaded(r)) return;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pending_rsp.push_back(predict_result(r));
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic tvru_pkg::req_type blank_item(input logic [2:0] f);
      tvru_pkg::req_type r;
      r = '0;
      r.func = f;
      return r;
   endfunction

   task automatic bus_write_item(input logic [2:0] rg, input logic [7:0] d);
      tvru_pkg::req_type r;
      r = blank_item(tvru_pkg::FUNC_WRITE);
      r.reg_index = rg;
      r.data = d;
      send_item(r);
   endtask

   task automatic bus_read_item(input logic [2:0] rg);
      tvru_pkg::req_type r;
      r = blank_item(tvru_pkg::FUNC_READ);
      r.reg_index = rg;
      send_item(r);
   endtask

   task automatic set_vaddr(input logic [13:0] a);
      bus_read_item(tvru_pkg::REG_STATUS);
      bus_write_item(tvru_pkg::REG_ADDR, {2'b00, a[13:8]});
      bus_write_item(tvru_pkg::REG_ADDR, a[7:0]);
   endtask

   function automatic tvru_pkg::req_type random_item();
      tvru_pkg::req_type r;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      r = raw[$bits(tvru_pkg::req_type)-1:0];
      r.func = 3'($urandom_range(7));
      r.pixel_y = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(239));
      if (r.func == tvru_pkg::FUNC_TICK && $urandom_range(3) != 0)
         r.cpu_cycles = 8'($urandom_range(40));
      return r;
   endfunction

   // checker
   always @(posedge clock) begin
      tvru_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transfer %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_data !== want.read_data || rsp_data.nmi_taken !== want.nmi_taken
                || rsp_data.pixel_color !== want.pixel_color) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch %0d: expected rd=%h nmi=%b rgb=%h, got rd=%h nmi=%b rgb=%h",
                           rsp_count, want.read_data, want.nmi_taken, want.pixel_color,
                           rsp_data.read_data, rsp_data.nmi_taken, rsp_data.pixel_color);
            end
         end
      end
   end

   // receiver stall process
   always @(posedge clock) begin
      if (hold_req != hold_done) begin
         hold_done <= hold_req;
         hold_cycles <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 3000000) begin
         $display("timeout");
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_registers();
      bus_write_item(tvru_pkg::REG_CTRL, 8'hFF);
      bus_write_item(tvru_pkg::REG_CTRL, 8'h00);
      bus_write_item(tvru_pkg::REG_MASK, 8'hA5);
      bus_write_item(tvru_pkg::REG_STATUS, 8'hFF);
      bus_write_item(REG_SPARE3, 8'h12);
      bus_write_item(REG_SPARE4, 8'h34);
      bus_write_item(tvru_pkg::REG_SCROLL, 8'h00);
      bus_write_item(tvru_pkg::REG_SCROLL, 8'hFF);
      for (int i = 0; i < 8; i++) bus_read_item(i[2:0]);
      send_item(blank_item(FUNC_SPARE6));
      send_item(blank_item(FUNC_SPARE7));
      send_item(blank_item(tvru_pkg::FUNC_POLL));
   endtask

   task automatic test_video_memory();
      tvru_pkg::req_type r;
      set_vaddr(14'h3F10);
      bus_write_item(tvru_pkg::REG_DATA, 8'hFF);
      set_vaddr(14'h3F00);
      bus_read_item(tvru_pkg::REG_DATA);
      set_vaddr(14'h3FFF);
      bus_write_item(tvru_pkg::REG_DATA, 8'h2A);
      bus_read_item(tvru_pkg::REG_DATA);
      set_vaddr(14'h1000);
      bus_write_item(tvru_pkg::REG_DATA, 8'h77);
      r = blank_item(tvru_pkg::FUNC_LOAD);
      r.pattern_addr = 13'h1FFF;
      r.data = 8'hFF;
      send_item(r);
      set_vaddr(14'h1FFF);
      bus_read_item(tvru_pkg::REG_DATA);
      bus_write_item(tvru_pkg::REG_CTRL, 8'h04);
      set_vaddr(14'h2FF0);
      bus_write_item(tvru_pkg::REG_DATA, 8'h5A);
      bus_read_item(tvru_pkg::REG_DATA);
      bus_write_item(tvru_pkg::REG_CTRL, 8'h00);
   endtask

   task automatic test_frame_timing();
      tvru_pkg::req_type r;
      bus_write_item(tvru_pkg::REG_CTRL, 8'h80);
      r = blank_item(tvru_pkg::FUNC_TICK);
      r.cpu_cycles = 8'd255;
      repeat (110) send_item(r);
      send_item(blank_item(tvru_pkg::FUNC_POLL));
      send_item(blank_item(tvru_pkg::FUNC_POLL));
      bus_read_item(tvru_pkg::REG_STATUS);
      r.cpu_cycles = 8'd0;
      send_item(r);
   endtask

   task automatic test_pixels();
      tvru_pkg::req_type r;
      // load the first sixteen tiles and point the top rows at them
      for (int a = 0; a < 256; a++) begin
         r = blank_item(tvru_pkg::FUNC_LOAD);
         r.pattern_addr = 13'(a);
         r.data = 8'($urandom);
         send_item(r);
      end
      set_vaddr(14'h3F00);
      for (int i = 0; i < 32; i++) bus_write_item(tvru_pkg::REG_DATA, 8'($urandom));
      set_vaddr(14'h2000);
      for (int i = 0; i < 64; i++) bus_write_item(tvru_pkg::REG_DATA, 8'($urandom_range(15)));
      set_vaddr(14'h23C0);
      for (int i = 0; i < 64; i++) bus_write_item(tvru_pkg::REG_DATA, 8'($urandom));
      r = blank_item(tvru_pkg::FUNC_PIXEL);
      repeat (64) begin
         r.pixel_x = 8'($urandom_range(255));
         r.pixel_y = 8'($urandom_range(15));
         send_item(r);
      end
      r.pixel_x = 8'd255; r.pixel_y = 8'd255;
      send_item(r);
      r.pixel_x = 8'd0; r.pixel_y = 8'd0;
      send_item(r);
   endtask

   task automatic test_random(input int unsigned count);
      repeat (count) send_item(random_item());
   endtask

   task automatic test_backpressure();
      tvru_pkg::req_type r;
      hold_req++;
      r = blank_item(tvru_pkg::FUNC_POLL);
      repeat (20) send_item(r);
   endtask

   initial begin
      m_ctrl = '0; m_mask = '0; m_status = '0; m_scroll_h = '0; m_scroll_v = '0;
      m_toggle = 1'b0; m_nmi = 1'b0; m_vaddr = '0; m_dot = 0; m_line = 0;
      foreach (m_pattern[i]) begin m_pattern[i] = '0; m_loaded[i] = 1'b0; end
      foreach (m_name[i]) m_name[i] = '0;
      foreach (m_palette[i]) m_palette[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_video_memory();
      test_frame_timing();
      test_pixels();
      send_idle_pct = 24; recv_idle_pct = 81;
      test_random(200);
      send_idle_pct = 81; recv_idle_pct = 24;
      test_random(200);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(180);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d transfers in, %0d results; %0d NMIs taken, %0d vblank reads",
               sent_count, rsp_count, nmi_seen, vblank_seen);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/tvru_pkg.sv
sv/tvru_timer.sv
sv/tile_video_register_unit_core.sv
verif/tile_video_register_unit_core_test.sv
